// ----- design/linear_probe_id_registry_assert.svh -----
// Assertion macros for the linear probe id registry.
// Uses the clk and rst_n names of the module that includes this file.
`ifndef LINEAR_PROBE_ID_REGISTRY_ASSERT_SVH
`define LINEAR_PROBE_ID_REGISTRY_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LPIR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LPIR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lpir_pkg.sv -----
// Shared types and codes for the linear probe id registry.
// No dependencies; used by linear_probe_id_registry, lpir_home and the testbench.
`default_nettype none

package lpir_pkg;

    // Field widths
    localparam int KEY_W    = 64;
    localparam int IDX_W    = 8;
    localparam int ROLE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int ACT_W    = 2;

    // Key bits folded into the home slot remainder per cycle
    localparam int DIGIT_W  = 4;

    // Default table size
    localparam int SLOTS_DEF = 256;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_FIND_CLAIM = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET_ROLE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GET_ROLE   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_FOUND   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_CLAIMED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ROLE    = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  slot;
        logic [ROLE_W-1:0] role_value;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]    slot_index;
        logic [ROLE_W-1:0]   role_out;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

`default_nettype wire

// ----- design/linear_probe_id_registry.sv -----
// Top level of the linear probe id registry: sequencer, key and role stores.
// Depends on lpir_pkg, lpir_ram, lpir_home and the assertion macro header.
//
// Usage:
//   req / req_valid / req_ready carries one request word (action, key, slot,
//   role_value); rsp / rsp_valid / rsp_ready returns exactly one result word
//   per request. Words move when valid and ready are both high.
//   Find-or-claim: the home slot is key modulo SLOTS; slots are then probed
//   one per cycle through the key store read port, wrapping at SLOTS, until
//   the key, an empty slot (claimed) or SLOTS probes (full).
//   The home slot is a bit-select of the key when SLOTS is a power of two,
//   otherwise a remainder folded 4 key bits per cycle. A zero key is
//   answered with STAT_ZERO and never probed.
//   One request is in work at a time; req_ready returns in the same cycle
//   as the result enters the output register.
//   Reset: a clearing pass writes zero to every slot of both stores, one
//   slot per cycle, with req_ready low.
//   Stall: a result waits in the output register; a new request may be taken
//   meanwhile, and its result waits until the previous one is taken.
`default_nettype none
`include "linear_probe_id_registry_assert.svh"

module linear_probe_id_registry #(
    parameter int SLOTS = lpir_pkg::SLOTS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output      logic           req_ready,
    input  wire lpir_pkg::req_t req,
    output      logic           rsp_valid,
    input  wire logic           rsp_ready,
    output      lpir_pkg::rsp_t rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int SW = ((AW > lpir_pkg::IDX_W) ? AW : lpir_pkg::IDX_W) + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_ROLE,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    lpir_pkg::req_t                  item_reg, item_next;
    logic [AW-1:0]                   pos_reg, pos_next;
    logic [AW-1:0]                   cnt_reg, cnt_next;
    logic [AW-1:0]                   clr_reg, clr_next;
    logic [lpir_pkg::IDX_W-1:0]      res_slot_reg, res_slot_next;
    logic [lpir_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                            res_get_reg, res_get_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    lpir_pkg::rsp_t                  rsp_reg, rsp_next;

    logic                            req_fire;
    logic                            home_start;
    logic                            home_done;
    logic [AW-1:0]                   home;
    logic [AW-1:0]                   pos_inc;
    logic [SW-1:0]                   pos_wide;
    logic [SW-1:0]                   slot_wide;
    logic                            slot_in_range;
    logic                            key_hit;
    logic                            key_empty;

    logic                            key_we, key_re;
    logic [AW-1:0]                   key_waddr, key_raddr;
    logic [lpir_pkg::KEY_W-1:0]      key_wdata, key_rdata;
    logic                            role_we, role_re;
    logic [AW-1:0]                   role_addr;
    logic [lpir_pkg::ROLE_W-1:0]     role_wdata, role_rdata;

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign home_start = req_fire && (req.action == lpir_pkg::ACT_FIND_CLAIM)
                        && (req.key != '0);

    // Probe position helpers
    assign pos_inc   = (pos_reg == AW'(SLOTS - 1)) ? '0 : pos_reg + AW'(1);
    assign pos_wide  = SW'(pos_reg);
    assign slot_wide = SW'(item_reg.slot);
    assign slot_in_range = (slot_wide < SW'(SLOTS));
    assign key_hit   = (key_rdata == item_reg.key);
    assign key_empty = (key_rdata == '0);

    lpir_home #(
        .SLOTS (SLOTS)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (home_start),
        .key   (req.key),
        .done  (home_done),
        .home  (home)
    );

    lpir_ram #(
        .WIDTH (lpir_pkg::KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    lpir_ram #(
        .WIDTH (lpir_pkg::ROLE_W),
        .DEPTH (SLOTS)
    ) u_role_ram (
        .clk   (clk),
        .we    (role_we),
        .waddr (role_addr),
        .wdata (role_wdata),
        .re    (role_re),
        .raddr (role_addr),
        .rdata (role_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        clr_next        = clr_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        res_get_next    = res_get_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        key_we     = 1'b0;
        key_waddr  = pos_reg;
        key_wdata  = item_reg.key;
        key_re     = 1'b0;
        key_raddr  = pos_inc;
        role_we    = 1'b0;
        role_re    = 1'b0;
        role_addr  = slot_wide[AW-1:0];
        role_wdata = item_reg.role_value;

        // Drop the result once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                key_we     = 1'b1;
                key_waddr  = clr_reg;
                key_wdata  = '0;
                role_we    = 1'b1;
                role_addr  = clr_reg;
                role_wdata = '0;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    item_next    = req;
                    res_get_next = 1'b0;
                    if (req.action == lpir_pkg::ACT_FIND_CLAIM)
                    begin
                        if (req.key == '0)
                        begin
                            res_slot_next   = '0;
                            res_status_next = lpir_pkg::STAT_ZERO;
                            state_next      = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_HASH;
                        end
                    end
                    else
                    begin
                        state_next = ST_ROLE;
                    end
                end
            end
            ST_HASH:
            begin
                // Issue the first probe at the home slot
                if (home_done)
                begin
                    key_re     = 1'b1;
                    key_raddr  = home;
                    pos_next   = home;
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (key_hit)
                begin
                    res_slot_next   = pos_wide[lpir_pkg::IDX_W-1:0];
                    res_status_next = lpir_pkg::STAT_FOUND;
                    state_next      = ST_EMIT;
                end
                else if (key_empty)
                begin
                    key_we          = 1'b1;
                    res_slot_next   = pos_wide[lpir_pkg::IDX_W-1:0];
                    res_status_next = lpir_pkg::STAT_CLAIMED;
                    state_next      = ST_EMIT;
                end
                else if (cnt_reg == AW'(SLOTS - 1))
                begin
                    res_slot_next   = '0;
                    res_status_next = lpir_pkg::STAT_FULL;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    // Advance to the next slot, wrapping at the end
                    key_re   = 1'b1;
                    pos_next = pos_inc;
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_ROLE:
            begin
                role_we = (item_reg.action == lpir_pkg::ACT_SET_ROLE) && slot_in_range;
                role_re = (item_reg.action == lpir_pkg::ACT_GET_ROLE) && slot_in_range;
                res_get_next    = role_re;
                res_slot_next   = item_reg.slot;
                res_status_next = lpir_pkg::STAT_ROLE;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.slot_index = res_slot_reg;
                    rsp_next.role_out   = res_get_reg ? role_rdata : '0;
                    rsp_next.status     = res_status_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        res_get_reg    <= res_get_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `LPIR_ASSERT_IMP(a_claim_empty, (state_reg == ST_CHECK) && key_we,
                     key_rdata == '0, "claim overwrote a held key")
    `LPIR_ASSERT_IMP(a_home_in_hash, home_done,
                     state_reg == ST_HASH, "home slot ready outside hash wait")
    `LPIR_ASSERT_NXT(a_emit_source, (state_reg != ST_EMIT) && !rsp_valid_reg,
                     !rsp_valid_reg, "result shown without emit")

endmodule

`default_nettype wire

// ----- design/lpir_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lpir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output      logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/lpir_home.sv -----
// Home slot unit: key modulo SLOTS, a bit-select for a power-of-two table,
// otherwise a remainder folded in DIGIT_W key bits per cycle. Uses lpir_pkg.
`default_nettype none

module lpir_home #(
    parameter int SLOTS = lpir_pkg::SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [lpir_pkg::KEY_W-1:0]   key,
    output      logic                         done,
    output      logic [$clog2(SLOTS)-1:0]     home
);

    localparam int AW   = $clog2(SLOTS);
    localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    logic          done_reg;
    logic [AW-1:0] home_reg;

    generate
        if (POW2)
        begin : g_pow2
            // Take the low key bits in the cycle after start
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    home_reg <= key[AW-1:0];
                end
            end
        end
        else
        begin : g_fold
            localparam int RW    = AW + 1;
            localparam int STEPS = lpir_pkg::KEY_W / lpir_pkg::DIGIT_W;
            localparam int CNT_W = $clog2(STEPS);

            logic                        busy_reg, busy_next;
            logic                        done_next;
            logic [CNT_W-1:0]            cnt_reg, cnt_next;
            logic [AW-1:0]               rem_next;
            logic [lpir_pkg::KEY_W-1:0]  sh_reg, sh_next;
            logic [RW-1:0]               acc;

            // Fold one digit of the key into the remainder
            always_comb
            begin
                busy_next = busy_reg;
                done_next = 1'b0;
                cnt_next  = cnt_reg;
                sh_next   = sh_reg;
                acc       = RW'(home_reg);
                rem_next  = home_reg;
                if (start)
                begin
                    busy_next = 1'b1;
                    cnt_next  = '0;
                    sh_next   = key;
                    rem_next  = '0;
                end
                else if (busy_reg)
                begin
                    for (int i = 0; i < lpir_pkg::DIGIT_W; i++)
                    begin
                        acc = {acc[AW-1:0], sh_reg[lpir_pkg::KEY_W-1-i]};
                        if (acc >= RW'(SLOTS))
                        begin
                            acc = acc - RW'(SLOTS);
                        end
                    end
                    rem_next = acc[AW-1:0];
                    sh_next  = sh_reg << lpir_pkg::DIGIT_W;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                    cnt_reg  <= cnt_next;
                end
            end

            always_ff @(posedge clk)
            begin
                sh_reg   <= sh_next;
                home_reg <= rem_next;
            end
        end
    endgenerate

    assign done = done_reg;
    assign home = home_reg;

endmodule

`default_nettype wire

// ----- tb/linear_probe_id_registry_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_id_registry: find-or-claim probing,
// role store access, zero-key and full-table cases, with random idling on both sides.
// Depends on lpir_pkg and the linear_probe_id_registry RTL.

module linear_probe_id_registry_tb;

    typedef logic [lpir_pkg::KEY_W-1:0]  key_t;
    typedef logic [lpir_pkg::IDX_W-1:0]  idx_t;
    typedef logic [lpir_pkg::ROLE_W-1:0] role_t;
    typedef logic [lpir_pkg::ACT_W-1:0]  act_t;

    localparam int   SLOTS      = lpir_pkg::SLOTS_DEF;
    localparam int   LOAD_CAP   = 160;
    localparam int   RANDOM_N   = 1000;
    localparam int   CYCLE_MAX  = 1250000;
    localparam int   DRAIN_WAIT = SLOTS + 24;
    localparam int   REPORT_MAX = 10;
    localparam act_t ACT_UNUSED = 2'd3;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    lpir_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    lpir_pkg::rsp_t rsp;

    // Registry mirror, advanced as each request word is taken
    key_t              mirror_keys [SLOTS];
    role_t             mirror_roles[SLOTS];
    lpir_pkg::rsp_t    awaited_rsp[$];

    // Request words waiting to be driven, and the keys handed out so far
    lpir_pkg::req_t    pending_req[$];
    key_t              issued_keys[$];
    bit                key_issued[key_t];

    int error_count = 0;
    int cycle_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit drv_calm    = 1'b0;
    bit mon_calm    = 1'b0;

    linear_probe_id_registry #(.SLOTS(SLOTS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one request word to the mirror and return the result it must give
    function automatic lpir_pkg::rsp_t registry_answer(lpir_pkg::req_t r);
        lpir_pkg::rsp_t a;
        int             pos;
        int             n;
        a            = '0;
        a.slot_index = r.slot;
        a.status     = lpir_pkg::STAT_ROLE;
        case (r.action)
            lpir_pkg::ACT_FIND_CLAIM:
            begin
                a.slot_index = '0;
                if (r.key == '0)
                    a.status = lpir_pkg::STAT_ZERO;
                else
                begin
                    a.status = lpir_pkg::STAT_FULL;
                    pos      = int'(r.key % 64'(SLOTS));
                    for (n = 0; n < SLOTS; n++)
                    begin
                        if (mirror_keys[pos] == r.key)
                        begin
                            a.slot_index = idx_t'(pos);
                            a.status     = lpir_pkg::STAT_FOUND;
                            break;
                        end
                        if (mirror_keys[pos] == '0)
                        begin
                            mirror_keys[pos] = r.key;
                            a.slot_index     = idx_t'(pos);
                            a.status         = lpir_pkg::STAT_CLAIMED;
                            break;
                        end
                        pos = (pos + 1) % SLOTS;
                    end
                end
            end
            lpir_pkg::ACT_SET_ROLE:
            begin
                if (r.slot < SLOTS)
                    mirror_roles[r.slot] = r.role_value;
            end
            lpir_pkg::ACT_GET_ROLE:
            begin
                if (r.slot < SLOTS)
                    a.role_out = mirror_roles[r.slot];
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    function automatic void push_req(act_t act, key_t k, idx_t s, role_t rv);
        lpir_pkg::req_t r;
        r.action     = act;
        r.key        = k;
        r.slot       = s;
        r.role_value = rv;
        pending_req.push_back(r);
    endfunction

    // Queue a lookup; slot and role fields carry noise the block must ignore
    function automatic void push_find(key_t k);
        push_req(lpir_pkg::ACT_FIND_CLAIM, k, idx_t'($urandom), role_t'($urandom));
        if (k != '0 && !key_issued.exists(k))
        begin
            key_issued[k] = 1'b1;
            issued_keys.push_back(k);
        end
    endfunction

    // Draw a nonzero key never used before; clustered keys pile up near the wrap
    function automatic key_t fresh_key(bit clustered);
        key_t k;
        do
        begin
            k = {$urandom, $urandom};
            if (clustered)
                k[7:0] = 8'($urandom_range(0, 15) + 248);
        end
        while (k == '0 || key_issued.exists(k));
        return k;
    endfunction

    function automatic key_t known_key();
        return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    endfunction

    // Compare one result word with the oldest expectation
    task automatic check_result(lpir_pkg::rsp_t got);
        lpir_pkg::rsp_t want;
        if (awaited_rsp.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_MAX)
                $display("ERROR: result word with none expected: slot %0d role %0d status %0d",
                         got.slot_index, got.role_out, got.status);
        end
        else
        begin
            want = awaited_rsp.pop_front();
            if (got.slot_index !== want.slot_index || got.role_out !== want.role_out ||
                got.status !== want.status)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("ERROR: expected slot %0d role %0d status %0d,",
                             want.slot_index, want.role_out, want.status,
                             " got slot %0d role %0d status %0d",
                             got.slot_index, got.role_out, got.status);
            end
        end
    endtask

    // Request driver: hold each word until taken, then idle for the drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                awaited_rsp.push_back(registry_answer(req));
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_req.size() > 0)
                begin
                    req       <= pending_req.pop_front();
                    req_valid <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        drv_calm = !drv_calm;
                    gap_left = drv_calm ? 0 : $urandom_range(0, 4);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each word taken, then stall for the drawn count
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_result(rsp);
                if ($urandom_range(0, 63) == 0)
                    mon_calm = !mon_calm;
                stall_left = mon_calm ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_MAX)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int i;
        int pick;
        for (i = 0; i < SLOTS; i++)
        begin
            mirror_keys[i]  = '0;
            mirror_roles[i] = '0;
        end

        // Directed: zero key, collisions, wrap at the top slot, field extremes
        push_find('0);
        push_find(64'h5);
        push_find(64'h5);
        push_find(64'h105);
        push_find(64'h205);
        push_find(64'h105);
        push_find(64'hFFFF_FFFF_FFFF_FFFF);
        push_find(64'h1FF);
        push_find(64'h8000_0000_0000_0000);
        push_find(64'hFFFF_FFFF_FFFF_FFFF);
        push_find(64'h1FF);
        push_req(lpir_pkg::ACT_SET_ROLE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'hFF);
        push_req(lpir_pkg::ACT_GET_ROLE, '0, 8'd0, 8'h00);
        push_req(lpir_pkg::ACT_SET_ROLE, '0, 8'd255, 8'hA5);
        push_req(lpir_pkg::ACT_GET_ROLE, 64'h1234, 8'd255, 8'h3C);
        push_req(lpir_pkg::ACT_GET_ROLE, '0, 8'd128, 8'hFF);
        push_req(lpir_pkg::ACT_SET_ROLE, '0, 8'd0, 8'h00);
        push_req(lpir_pkg::ACT_GET_ROLE, '0, 8'd0, 8'hFF);
        push_req(ACT_UNUSED, 64'hDEAD_BEEF_0000_0001, 8'hAB, 8'h5A);
        push_req(ACT_UNUSED, '0, 8'd0, 8'hFF);
        push_req(lpir_pkg::ACT_GET_ROLE, '0, 8'd255, 8'h00);

        // Random: known-key lookups, new keys up to a moderate load, zero keys, role and unused-action traffic
        for (i = 0; i < RANDOM_N; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                push_find(known_key());
            else if (pick < 65)
                push_find(issued_keys.size() < LOAD_CAP ? fresh_key($urandom_range(0, 1))
                                                        : known_key());
            else if (pick < 68)
                push_find('0);
            else if (pick < 83)
                push_req(lpir_pkg::ACT_SET_ROLE, {$urandom, $urandom},
                         idx_t'($urandom), role_t'($urandom));
            else if (pick < 97)
                push_req(lpir_pkg::ACT_GET_ROLE, {$urandom, $urandom},
                         idx_t'($urandom), role_t'($urandom));
            else
                push_req(ACT_UNUSED, {$urandom, $urandom},
                         idx_t'($urandom), role_t'($urandom));
        end

        // Fill the table, then probe it full with new and known keys
        while (issued_keys.size() < SLOTS)
        begin
            if ($urandom_range(0, 3) == 0)
                push_find(known_key());
            else
                push_find(fresh_key($urandom_range(0, 1)));
        end
        for (i = 0; i < 6; i++)
        begin
            push_find(fresh_key($urandom_range(0, 1)));
            push_find(known_key());
        end
        push_find('0);
        push_req(lpir_pkg::ACT_SET_ROLE, '0, idx_t'($urandom), role_t'($urandom));
        push_req(lpir_pkg::ACT_GET_ROLE, '0, idx_t'($urandom), '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain, then allow for any stray result
        while (pending_req.size() > 0 || req_valid || awaited_rsp.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- linear_probe_id_registry.f -----
+incdir+design
design/lpir_pkg.sv
design/lpir_ram.sv
design/lpir_home.sv
design/linear_probe_id_registry.sv
tb/linear_probe_id_registry_tb.sv
